// ----- sv/row_softmax_top_macros.svh -----
// Assertion macros for the row softmax RTL.
// No dependencies; included by rsm_ctrl, the module that carries checks.
`ifndef ROW_SOFTMAX_TOP_MACROS_SVH
`define ROW_SOFTMAX_TOP_MACROS_SVH

// property must hold at every edge outside reset
`define RSM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("row softmax check failed");

// condition must never be seen outside reset
`define RSM_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("row softmax illegal condition");

`endif

// ----- sv/rsm_pkg.sv -----
// Package for the row softmax block: widths, constants, FSM state,
// controller/datapath command and status structs, exp table builder.
package rsm_pkg;

	localparam int MAX_ROW_DEF   = 64;
	localparam int EXP_DEPTH_DEF = 64;

	localparam int LOGIT_W  = 16;
	localparam int PROB_W   = 16;
	localparam int POS_W    = 6;
	localparam int SUM_W    = 22;
	localparam int QUO_W    = 38;
	localparam int FAC_W    = 23;
	localparam int DIVC_W   = 6;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 24;

	localparam logic [14:0]      LOG2E_Q14 = 15'd23637;
	localparam logic [SUM_W-1:0] TOTAL_MAX = {SUM_W{1'b1}};
	localparam logic [PROB_W:0]  PROB_ONE  = 17'd32768;
	localparam logic [LOGIT_W-1:0] LOGIT_MIN = 16'h8000;

	localparam longint unsigned LN2_Q30 = 64'd744261118;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RD,
		S_MUL1,
		S_MUL2,
		S_EXPV,
		S_ACC,
		S_DIV,
		S_OMUL,
		S_ORND,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic row_done;
		logic ptr_clr;
		logic ptr_inc;
		logic rd;
		logic mul1;
		logic mul2;
		logic expv;
		logic acc_clr;
		logic acc;
		logic div_start;
		logic omul;
		logic oload;
	} cmd_t;

	typedef struct packed {
		logic ptr_last;
		logic div_done;
		logic out_valid;
		logic out_taken;
	} sts_t;

	// elaboration-time long division, shift and subtract
	function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round(32768 * 2^(-i/depth)) via integer series in Q30
	function automatic logic [15:0] exp_entry(int unsigned i, int unsigned depth);
		longint unsigned y;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned r;
		y    = udiv(longint'(i) * LN2_Q30, longint'(depth));
		term = ONE_Q30;
		pos  = ONE_Q30;
		neg  = 0;
		for (int unsigned k = 1; k <= 24; k++) begin
			term = udiv(term * y, longint'(k) * ONE_Q30);
			if (k[0]) neg += term;
			else pos += term;
		end
		r = (pos > neg) ? (pos - neg) : 64'd0;
		r = (r + 64'd16384) >> 15;
		if (r > 64'd32768) r = 64'd32768;
		return r[15:0];
	endfunction

endpackage

// ----- sv/rsm_ctrl.sv -----
// Row softmax controller: sequences load, exp/sum pass, reciprocal and
// output pass. Depends on rsm_pkg and row_softmax_top_macros.svh.
`include "row_softmax_top_macros.svh"
module rsm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  rsm_pkg::sts_t sts,
	output rsm_pkg::cmd_t cmd
);

	rsm_pkg::state_t state_q, state_d;
	logic out_pass_q, out_pass_d;
	logic accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rsm_pkg::S_LOAD;
			out_pass_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			out_pass_q <= out_pass_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		out_pass_d = out_pass_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			rsm_pkg::S_LOAD: begin
				in_ready = 1'b1;
				cmd.load = accept;
				if (accept && in_last) begin
					cmd.ptr_clr = 1'b1;
					cmd.acc_clr = 1'b1;
					out_pass_d  = 1'b0;
					state_d     = rsm_pkg::S_RD;
				end
			end
			rsm_pkg::S_RD: begin
				cmd.rd  = 1'b1;
				state_d = rsm_pkg::S_MUL1;
			end
			rsm_pkg::S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = rsm_pkg::S_MUL2;
			end
			rsm_pkg::S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = rsm_pkg::S_EXPV;
			end
			rsm_pkg::S_EXPV: begin
				cmd.expv = 1'b1;
				state_d  = out_pass_q ? rsm_pkg::S_OMUL : rsm_pkg::S_ACC;
			end
			rsm_pkg::S_ACC: begin
				cmd.acc = 1'b1;
				if (sts.ptr_last) begin
					cmd.div_start = 1'b1;
					state_d       = rsm_pkg::S_DIV;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = rsm_pkg::S_RD;
				end
			end
			rsm_pkg::S_DIV: begin
				if (sts.div_done) begin
					cmd.ptr_clr = 1'b1;
					out_pass_d  = 1'b1;
					state_d     = rsm_pkg::S_RD;
				end
			end
			rsm_pkg::S_OMUL: begin
				cmd.omul = 1'b1;
				state_d  = rsm_pkg::S_ORND;
			end
			rsm_pkg::S_ORND: begin
				cmd.oload = 1'b1;
				state_d   = rsm_pkg::S_EMIT;
			end
			rsm_pkg::S_EMIT: begin
				if (sts.out_taken) begin
					if (sts.ptr_last) begin
						cmd.row_done = 1'b1;
						state_d      = rsm_pkg::S_LOAD;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = rsm_pkg::S_RD;
					end
				end
			end
			default: state_d = rsm_pkg::S_LOAD;
		endcase
	end

	`RSM_NEVER(a_no_overlap, clk, arst_n, in_ready && sts.out_valid)
	`RSM_ASSERT(a_valid_in_emit, clk, arst_n, sts.out_valid |-> state_q == rsm_pkg::S_EMIT)
	`RSM_ASSERT(a_div_in_sum, clk, arst_n, state_q == rsm_pkg::S_DIV |-> !out_pass_q)

endmodule

// ----- sv/rsm_div.sv -----
// Restoring divider: one quotient bit per cycle of 2^37 / divisor.
// Depends on rsm_pkg.
module rsm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rsm_pkg::SUM_W-1:0]   divisor,
	output logic                        done,
	output logic [rsm_pkg::QUO_W-1:0]   quotient
);

	localparam logic [rsm_pkg::DIVC_W-1:0] STEPS = rsm_pkg::DIVC_W'(rsm_pkg::QUO_W);

	logic [rsm_pkg::DIVC_W-1:0] cnt_q;
	logic [rsm_pkg::SUM_W-1:0]  rem_q;
	logic [rsm_pkg::QUO_W-1:0]  quo_q;
	logic [rsm_pkg::SUM_W:0]    sh;
	logic [rsm_pkg::SUM_W:0]    diff;
	logic                       ge;

	assign sh       = {rem_q, (cnt_q == STEPS)};
	assign ge       = sh >= {1'b0, divisor};
	assign diff     = sh - {1'b0, divisor};
	assign done     = (cnt_q == rsm_pkg::DIVC_W'(1));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[rsm_pkg::SUM_W-1:0] : sh[rsm_pkg::SUM_W-1:0];
			quo_q <= {quo_q[rsm_pkg::QUO_W-2:0], ge};
		end
	end

endmodule

// ----- sv/rsm_dp.sv -----
// Row softmax datapath: row memory, running max, exp unit, saturating sum,
// reciprocal, output scaling and result register. Depends on rsm_pkg, rsm_div.
module rsm_dp #(
	parameter int MAX_ROW         = rsm_pkg::MAX_ROW_DEF,
	parameter int EXP_TABLE_DEPTH = rsm_pkg::EXP_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rsm_pkg::cmd_t                      cmd,
	output rsm_pkg::sts_t                      sts,
	input  logic signed [rsm_pkg::LOGIT_W-1:0] logit,
	output logic [rsm_pkg::PROB_W-1:0]         probability,
	output logic [rsm_pkg::POS_W-1:0]          position,
	output logic                               final_out,
	output logic                               out_valid,
	input  logic                               out_ready
);

	localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
	localparam int CW = $clog2(MAX_ROW + 1);
	localparam int IW = $clog2(EXP_TABLE_DEPTH);
	localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);
	localparam logic [CW-1:0] ROW_FULL = CW'(MAX_ROW);

	logic [rsm_pkg::LOGIT_W-1:0] mem [MAX_ROW];
	logic [15:0] tab [EXP_TABLE_DEPTH];

	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
		localparam logic [15:0] ENTRY = rsm_pkg::exp_entry(g, EXP_TABLE_DEPTH);
		assign tab[g] = ENTRY;
	end

	logic [CW-1:0]                      count_q;
	logic signed [rsm_pkg::LOGIT_W-1:0] max_q;
	logic [AW-1:0]                      ptr_q;
	logic [rsm_pkg::LOGIT_W-1:0]        rdata_q;
	logic [30:0]                        t_s1;
	logic [6:0]                         k_s2;
	logic [IW-1:0]                      idx_s2;
	logic [15:0]                        e_q;
	logic [rsm_pkg::SUM_W-1:0]          total_q;
	logic [rsm_pkg::FAC_W+15:0]         prod_q;
	logic                               valid_q;

	logic signed [rsm_pkg::LOGIT_W:0] diff;
	logic [23+DW:0]                   fprod;
	logic [rsm_pkg::SUM_W:0]          sum;
	logic [rsm_pkg::QUO_W-1:0]        quo;
	logic [rsm_pkg::FAC_W-1:0]        factor;
	logic [rsm_pkg::FAC_W+15:0]       rnd;
	logic [rsm_pkg::PROB_W:0]         p;
	logic                             div_done;
	logic                             taken;

	assign diff  = {max_q[rsm_pkg::LOGIT_W-1], max_q}
		- {rdata_q[rsm_pkg::LOGIT_W-1], rdata_q};
	assign fprod = t_s1[23:0] * DW'(EXP_TABLE_DEPTH);
	assign sum   = {1'b0, total_q} + (rsm_pkg::SUM_W+1)'(e_q);
	assign rnd   = prod_q + (rsm_pkg::FAC_W+16)'(1 << 21);
	assign p     = rnd[22 +: rsm_pkg::PROB_W+1];
	assign taken = valid_q && out_ready;

	always_comb begin
		if (total_q == '0) factor = rsm_pkg::FAC_W'(rsm_pkg::TOTAL_MAX);
		else if (|quo[rsm_pkg::QUO_W-1:rsm_pkg::FAC_W]) factor = '1;
		else factor = quo[rsm_pkg::FAC_W-1:0];
	end

	rsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= rsm_pkg::LOGIT_MIN;
			ptr_q   <= '0;
			total_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.row_done) begin
				count_q <= '0;
				max_q   <= rsm_pkg::LOGIT_MIN;
			end else if (cmd.load && count_q < ROW_FULL) begin
				count_q <= count_q + 1'b1;
				if (logit > max_q) max_q <= logit;
			end
			if (cmd.ptr_clr) ptr_q <= '0;
			else if (cmd.ptr_inc) ptr_q <= ptr_q + 1'b1;
			if (cmd.acc_clr) total_q <= '0;
			else if (cmd.acc) total_q <= sum[rsm_pkg::SUM_W] ? rsm_pkg::TOTAL_MAX
				: sum[rsm_pkg::SUM_W-1:0];
			if (cmd.oload) valid_q <= 1'b1;
			else if (taken) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && count_q < ROW_FULL) mem[count_q[AW-1:0]] <= logit;
		if (cmd.rd) rdata_q <= mem[ptr_q];
		if (cmd.mul1) t_s1 <= diff[15:0] * rsm_pkg::LOG2E_Q14;
		if (cmd.mul2) begin
			k_s2   <= t_s1[30:24];
			idx_s2 <= fprod[24 +: IW];
		end
		if (cmd.expv) e_q <= (k_s2 >= 7'd16) ? 16'd0 : (tab[idx_s2] >> k_s2[3:0]);
		if (cmd.omul) prod_q <= e_q * factor;
		if (cmd.oload) begin
			probability <= (p > rsm_pkg::PROB_ONE) ? rsm_pkg::PROB_ONE[rsm_pkg::PROB_W-1:0]
				: p[rsm_pkg::PROB_W-1:0];
			position    <= rsm_pkg::POS_W'(ptr_q);
			final_out   <= sts.ptr_last;
		end
	end

	assign out_valid     = valid_q;
	assign sts.ptr_last  = (CW'(ptr_q) == count_q - 1'b1);
	assign sts.div_done  = div_done;
	assign sts.out_valid = valid_q;
	assign sts.out_taken = taken;

endmodule

// ----- sv/row_softmax_top.sv -----
// Channel | dir | contents
// s_*     | in  | tdata[15:0] logit (Q5.10), tlast row_end
// m_*     | out | tdata[15:0] probability, [21:16] position, tlast final_out
// Rows are stored on input, one transfer a cycle while loading.
// At row end: an exp and sum pass over the elements one at a time, the bit-serial
// reciprocal divider, then an output pass one element at a time (held by output stalls).
// Input is not accepted from row end until the last result transfer.
// Asynchronous active-low reset; no clearing pass is needed.
module row_softmax_top #(
	parameter int MAX_ROW         = rsm_pkg::MAX_ROW_DEF,
	parameter int EXP_TABLE_DEPTH = rsm_pkg::EXP_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rsm_pkg::S_DATA_W-1:0]  s_tdata,  // [15:0] logit
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rsm_pkg::M_DATA_W-1:0]  m_tdata,  // [15:0] probability, [21:16] position
	output logic                          m_tlast
);

	rsm_pkg::cmd_t cmd;
	rsm_pkg::sts_t sts;
	logic [rsm_pkg::PROB_W-1:0] probability;
	logic [rsm_pkg::POS_W-1:0]  position;

	rsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsm_dp #(
		.MAX_ROW         (MAX_ROW),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.logit       (s_tdata[rsm_pkg::LOGIT_W-1:0]),
		.probability (probability),
		.position    (position),
		.final_out   (m_tlast),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready)
	);

	assign m_tdata = {2'b00, position, probability};

endmodule

// ----- tb/sv/tb_row_softmax_top.sv -----
// Self-checking bench for row_softmax_top: drives rows of Q5.10 logits with
// tlast, predicts each Q1.15 probability and compares every output transfer.
// Depends on rsm_pkg and row_softmax_top.
module tb_row_softmax_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] prob;
		logic [5:0]  pos;
		logic        fin;
	} prob_t;

	class softmax_sb;
		logic signed [15:0] row_q[$];
		logic signed [15:0] row_max;
		logic [15:0]        exp_lut[64];
		prob_t              pending[$];
		int                 errors;

		function new();
			longint unsigned y, term, pos, neg, r;
			for (int i = 0; i < 64; i++) begin
				y = (longint'(i) * 64'd744261118) / 64;
				term = 64'd1073741824;
				pos = term;
				neg = 0;
				for (int k = 1; k <= 24; k++) begin
					term = (term * y) / (longint'(k) * 64'd1073741824);
					if (k % 2) neg += term;
					else pos += term;
				end
				r = (pos > neg) ? pos - neg : 0;
				r = (r + 16384) >> 15;
				if (r > 32768) r = 32768;
				exp_lut[i] = r[15:0];
			end
			row_max = 16'sh8000;
			errors = 0;
		endfunction

		function longint unsigned exp_val(logic signed [15:0] x);
			longint unsigned n, t, k, idx;
			n = longint'(int'(row_max) - int'(x));
			t = n * 23637;
			k = t >> 24;
			idx = ((t & 64'hFFFFFF) * 64) >> 24;
			if (k >= 16) return 0;
			return longint'(exp_lut[idx]) >> k;
		endfunction

		function void note_logit(logic [15:0] d, logic last);
			longint unsigned total, recip, p;
			prob_t r;
			if (row_q.size() < 64) begin
				row_q.push_back(d);
				if ($signed(d) > row_max) row_max = d;
			end
			if (!last) return;
			total = 0;
			foreach (row_q[j]) total += exp_val(row_q[j]);
			if (total > 4194303) total = 4194303;
			recip = (total == 0) ? 4194303 : (64'd1 << 37) / total;
			foreach (row_q[j]) begin
				p = (exp_val(row_q[j]) * recip + (64'd1 << 21)) >> 22;
				if (p > 32768) p = 32768;
				r.prob = p[15:0];
				r.pos = j[5:0];
				r.fin = (j == row_q.size() - 1);
				pending.push_back(r);
			end
			row_q.delete();
			row_max = 16'sh8000;
		endfunction

		function void check_prob(logic [23:0] d, logic last);
			prob_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected transfer: expected none, actual %h last %b",
					$time, d, last);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[15:0] !== e.prob || d[21:16] !== e.pos || last !== e.fin
					|| d[23:22] !== 2'b00) begin
				$display("%0t mismatch: expected prob %0d pos %0d last %b,",
					$time, e.prob, e.pos, e.fin,
					" actual prob %0d pos %0d last %b",
					d[15:0], d[21:16], last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, s_tlast = 0;
	logic [15:0] s_tdata = 0;
	logic m_tvalid, m_tready = 0, m_tlast;
	logic [23:0] m_tdata;
	longint cycles = 0;
	int stall_mode = 0;
	softmax_sb sb = new();

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	row_softmax_top dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: accepts and checks, stall pattern varies by mode
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_prob(m_tdata, m_tlast);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= cycles[2];
		endcase
	end

	task automatic push_logit(logic [15:0] d, logic last);
		if ($urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_logit(d, last);
	endtask

	task automatic send_row(int len, int spread);
		logic [15:0] base;
		base = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			if (spread == 0) push_logit(16'($urandom), i == len - 1);
			else push_logit(16'(int'(base) + int'($urandom_range(0, spread)) - spread / 2),
				i == len - 1);
		end
	endtask

	initial begin
		int len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		push_logit(16'h7FFF, 1);
		push_logit(16'h8000, 1);
		push_logit(16'h7FFF, 0);
		push_logit(16'h8000, 1);
		push_logit(16'h0000, 0);
		push_logit(16'h0000, 0);
		push_logit(16'h0400, 0);
		push_logit(16'hFC00, 1);
		push_logit(16'h5555, 0);
		push_logit(16'hAAAA, 0);
		push_logit(16'h0001, 1);
		stall_mode = 2;
		send_row(70, 2000);
		for (int r = 0; r < 37; r++) begin
			stall_mode = $urandom_range(0, 3);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
			case ($urandom_range(0, 2))
				0: send_row(len, 0);
				1: send_row(len, 4096);
				default: send_row(len, 64);
			endcase
		end
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+sv
sv/rsm_pkg.sv
sv/rsm_ctrl.sv
sv/rsm_div.sv
sv/rsm_dp.sv
sv/row_softmax_top.sv
tb/sv/tb_row_softmax_top.sv
